// ===== sv/unity_gain_fir_trajectory_smoother_unit_assert.svh =====
// Assertion macros for the trajectory smoother.
// Used by the top level only; define NO_ASSERTIONS to drop them.
`ifndef UNITY_GAIN_FIR_TRAJECTORY_SMOOTHER_UNIT_ASSERT_SVH
`define UNITY_GAIN_FIR_TRAJECTORY_SMOOTHER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UGF_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define UGF_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define UGF_ASSERT_IMP(lbl, a, c)
`define UGF_ASSERT_NXT(lbl, a, c)
`endif
`endif

// ===== sv/ugfts_pkg.sv =====
// Shared types and constants for the trajectory smoother.
// No dependencies.
package ugfts_pkg;
  localparam int TAPS = 8;
  localparam int NCOEF = 8;
  localparam int IDXW = $clog2(TAPS + 1);
  localparam logic [2:0] CFG_IDX_MAX = 3'd7;
  localparam logic [1:0] CNT_IDLE = 2'd0;
  localparam logic [1:0] CNT_FIRST = 2'd1;
  localparam logic [1:0] CNT_RUN = 2'd2;

  // Control from the sequencer to every tap cell.
  typedef struct packed {
    logic        load;   // parallel load of primed values
    logic        shift;  // shift toward the oldest entry
    logic        rotate; // rotate oldest -> newest for the MAC walk
    logic [31:0] sin;    // new newest entry on shift
  } cell_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ===== sv/ugfts_cell.sv =====
// One history cell of the smoother: holds one entry and its coefficient.
// Depends on ugfts_pkg.
module ugfts_cell (
  input  logic                    clk,
  input  ugfts_pkg::cell_ctl_t    ctl,
  input  logic signed [31:0]      load_val,
  input  logic signed [31:0]      nb_val,
  input  logic signed [15:0]      nb_coef,
  input  logic                    coef_we,
  input  logic signed [15:0]      coef_wd,
  output logic signed [31:0]      val,
  output logic signed [15:0]      coef
);
  logic signed [31:0] val_r;
  logic signed [15:0] coef_r;

  // Reset values are loaded by the top level's clear through the load and coefficient write ports.
  always_ff @(posedge clk) begin
    if (ctl.load) val_r <= load_val;
    else if (ctl.shift || ctl.rotate) val_r <= nb_val;
    if (coef_we) coef_r <= coef_wd;
    else if (ctl.rotate) coef_r <= nb_coef;
  end
  assign val = val_r;
  assign coef = coef_r;
endmodule

// ===== sv/ugfts_div.sv =====
// Serial signed divider: 64-bit dividend by 20-bit divisor, truncating.
// Depends on ugfts_pkg.
module ugfts_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [19:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  logic [63:0] q_r, q_nxt;
  logic [20:0] rem_r, rem_nxt;
  logic [19:0] d_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [20:0] trial;
  logic [63:0] qs;

  always_comb begin
    trial = {rem_r[19:0], q_r[63]};
    rem_nxt = trial;
    q_nxt = {q_r[62:0], 1'b0};
    if (trial >= {1'b0, d_r}) begin
      rem_nxt = trial - {1'b0, d_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'd0;
        q_r <= num[63] ? 64'(-num) : num;
        d_r <= den[19] ? 20'(-den) : den;
        rem_r <= '0;
        neg_r <= num[63] ^ den[19];
      end else if (busy_r) begin
        q_r <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign qs = neg_r ? 64'(-q_r) : q_r;
  assign quo = ugfts_pkg::sat32(qs);
endmodule

// ===== sv/unity_gain_fir_trajectory_smoother_unit.sv =====
// Top level of the unity-gain FIR trajectory smoother.
// Depends on ugfts_pkg, ugfts_cell, ugfts_div and the assertion header.
//
// Usage: one position sample per in_ transaction, flagged first/last.
// Results leave on the out_ channel, one per input, in order.
// Coefficients are written on the cfg_ channel (index 0..7) while idle.
// The history is a chain of eight cells. Each inner sample shifts in, then
// the chain rotates eight times past a single multiply-accumulate unit, and
// a 64-step restoring divider divides the dot product by the tap sum.
// A pass-through sample's result is registered on the accepting edge; an inner
// sample walks the MAC chain, drains the product and then runs the divider,
// which is skipped when the tap sum is zero. The second sample of a trajectory
// first primes the history. One item is in work at a time: in_ready returns
// the cycle after the result is taken, so a new sample waits until the last
// result has left.
// After reset a 1-cycle clear loads the chain and default coefficients.
// A stalled receiver holds the result register; input waits behind it.
`include "unity_gain_fir_trajectory_smoother_unit_assert.svh"
module unity_gain_fir_trajectory_smoother_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_position,
  input  logic        in_first_sample,
  input  logic        in_last_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_smoothed_position,
  output logic        out_was_filtered,
  output logic        out_zero_gain_error,
  output logic        out_end_of_trajectory,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_PRIME = 3'd2,
                         S_SHIFT = 3'd3, S_MAC = 3'd4, S_DIV = 3'd5, S_OUT = 3'd6;
  localparam int N = ugfts_pkg::TAPS;

  logic [2:0] st_r;
  logic [1:0] cnt_r;
  logic signed [31:0] start_r, x_r;
  logic [ugfts_pkg::IDXW-1:0] k_r;
  logic signed [63:0] acc_r;
  logic signed [19:0] gain_r;
  logic signed [47:0] prod_r;
  logic prod_v_r;
  ugfts_pkg::cell_ctl_t ctl;
  logic signed [31:0] vals [N];
  logic signed [15:0] coefs [N];
  logic signed [31:0] loads [N];
  logic signed [15:0] coef_wd [N];
  logic coef_we [N];
  logic div_start, div_done;
  logic signed [31:0] quo;
  logic signed [32:0] delta;

  assign delta = 33'(start_r) - 33'(x_r);

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [2:0] ci;
    assign ci = 3'(ugfts_pkg::NCOEF - N + i);
    always_comb begin
      loads[i] = (st_r == S_CLR) ? 32'sd0 : ugfts_pkg::sat32(
        64'(start_r) + 64'(delta) * 64'(N - i));
      coef_we[i] = (st_r == S_CLR) || (cfg_valid && cfg_ready && cfg_index == ci);
      coef_wd[i] = (st_r == S_CLR) ? ((ci == ugfts_pkg::CFG_IDX_MAX) ? 16'sd16384 : 16'sd0)
                                   : cfg_data;
    end
    ugfts_cell u_cell (
      .clk(clk), .ctl(ctl), .load_val(loads[i]),
      .nb_val((i == N - 1) ? (ctl.rotate ? vals[0] : ctl.sin) : vals[(i + 1) % N]),
      .nb_coef(coefs[(i + 1) % N]), .coef_we(coef_we[i]), .coef_wd(coef_wd[i]),
      .val(vals[i]), .coef(coefs[i]));
  end

  always_comb begin
    ctl = '0;
    ctl.sin = x_r;
    ctl.load = (st_r == S_CLR) || (st_r == S_PRIME);
    ctl.shift = (st_r == S_SHIFT);
    ctl.rotate = (st_r == S_MAC) && (k_r < ugfts_pkg::IDXW'(N));
  end

  assign in_ready = (st_r == S_IDLE) && !out_valid;
  assign cfg_ready = (st_r == S_IDLE);
  assign div_start = (st_r == S_MAC) && (k_r == ugfts_pkg::IDXW'(N)) && !prod_v_r
                     && (gain_r != 0);

  ugfts_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(acc_r),
                   .den(gain_r), .done(div_done), .quo(quo));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      cnt_r <= ugfts_pkg::CNT_IDLE;
      out_valid <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_CLR: st_r <= S_IDLE;
        S_IDLE: if (in_valid && in_ready) begin
          x_r <= in_sample_position;
          out_smoothed_position <= in_sample_position;
          out_was_filtered <= 1'b0;
          out_zero_gain_error <= 1'b0;
          out_end_of_trajectory <= in_last_sample;
          if (in_first_sample || (cnt_r == ugfts_pkg::CNT_IDLE && !in_last_sample)) begin
            start_r <= in_sample_position;
            cnt_r <= in_last_sample ? ugfts_pkg::CNT_IDLE : ugfts_pkg::CNT_FIRST;
            out_valid <= 1'b1;
          end else if (in_last_sample) begin
            cnt_r <= ugfts_pkg::CNT_IDLE;
            out_valid <= 1'b1;
          end else begin
            st_r <= (cnt_r == ugfts_pkg::CNT_FIRST) ? S_PRIME : S_SHIFT;
            cnt_r <= ugfts_pkg::CNT_RUN;
          end
        end
        S_PRIME: st_r <= S_SHIFT;
        S_SHIFT: begin
          st_r <= S_MAC;
          k_r <= '0;
          acc_r <= '0;
          gain_r <= '0;
          prod_v_r <= 1'b0;
        end
        S_MAC: begin
          if (k_r < ugfts_pkg::IDXW'(N)) begin
            prod_r <= 48'(vals[0]) * 48'(coefs[0]);
            gain_r <= gain_r + 20'(coefs[0]);
            k_r <= k_r + ugfts_pkg::IDXW'(1);
          end
          prod_v_r <= (k_r < ugfts_pkg::IDXW'(N));
          if (prod_v_r) acc_r <= acc_r + 64'(prod_r);
          if (k_r == ugfts_pkg::IDXW'(N) && !prod_v_r) begin
            if (gain_r == 0) begin
              out_zero_gain_error <= 1'b1;
              st_r <= S_OUT;
            end else st_r <= S_DIV;
          end
        end
        S_DIV: if (div_done) begin
          out_smoothed_position <= quo;
          out_was_filtered <= 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `UGF_ASSERT_IMP(a_no_in_busy, (in_valid && in_ready), (st_r == S_IDLE))
  `UGF_ASSERT_IMP(a_flag_excl, out_valid, !(out_was_filtered && out_zero_gain_error))
  `UGF_ASSERT_NXT(a_out_hold, (out_valid && !out_ready), out_valid)
  `UGF_ASSERT_IMP(a_div_gain, div_start, (gain_r != 0))
endmodule

// ===== tb/tb_unity_gain_fir_trajectory_smoother_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the unity-gain FIR trajectory smoother: directed cases, then random trajectories.
// Depends on ugfts_pkg and the unity_gain_fir_trajectory_smoother_unit RTL.
module tb_unity_gain_fir_trajectory_smoother_unit;

  typedef struct {
    logic signed [31:0] pos;
    logic               first;
    logic               last;
    bit                 known;
    logic signed [31:0] exp_pos;
    logic               exp_filt;
    logic               exp_zerr;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] pos;
    logic               filt;
    logic               zerr;
    logic               eot;
  } smooth_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_sample_position = '0;
  logic in_first_sample = 1'b0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_smoothed_position;
  logic out_was_filtered, out_zero_gain_error, out_end_of_trajectory;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  unity_gain_fir_trajectory_smoother_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  logic signed [15:0] tap_w [ugfts_pkg::NCOEF];
  logic signed [31:0] hist [ugfts_pkg::TAPS];
  logic signed [31:0] traj_start;
  logic [1:0] traj_phase;

  smooth_res_t pending_q[$];
  int n_err = 0;
  int n_res = 0;
  int n_filt = 0;
  int n_zerr = 0;
  bit hold_rx = 1'b0;
  int rx_off = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic smooth_res_t smooth_predict(input logic signed [31:0] x,
                                                 input logic first, input logic last);
    smooth_res_t r;
    logic signed [63:0] delta, dot, gain, c;
    r.pos = x;
    r.filt = 1'b0;
    r.zerr = 1'b0;
    r.eot = last;
    if (first || (traj_phase == ugfts_pkg::CNT_IDLE && !last)) begin
      traj_start = x;
      traj_phase = last ? ugfts_pkg::CNT_IDLE : ugfts_pkg::CNT_FIRST;
    end else if (last) begin
      traj_phase = ugfts_pkg::CNT_IDLE;
    end else begin
      if (traj_phase == ugfts_pkg::CNT_FIRST) begin
        delta = 64'(traj_start) - 64'(x);
        for (int k = 0; k < ugfts_pkg::TAPS; k++)
          hist[k] = clamp32(64'(traj_start) + 64'(ugfts_pkg::TAPS - k) * delta);
        traj_phase = ugfts_pkg::CNT_RUN;
      end
      for (int k = 0; k < ugfts_pkg::TAPS - 1; k++) hist[k] = hist[k + 1];
      hist[ugfts_pkg::TAPS - 1] = x;
      dot = 0;
      gain = 0;
      for (int k = 0; k < ugfts_pkg::TAPS; k++) begin
        c = 64'(tap_w[ugfts_pkg::NCOEF - ugfts_pkg::TAPS + k]);
        dot += 64'(hist[k]) * c;
        gain += c;
      end
      if (gain == 0) r.zerr = 1'b1;
      else begin
        r.pos = clamp32(dot / gain);
        r.filt = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_err++;
    $display("MISMATCH result %0d %s: got %h expected %h", n_res, what, got, want);
  endtask

  task automatic expect_res(input smooth_res_t r);
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [31:0] x, input logic f, input logic l);
    in_valid = 1'b1;
    in_sample_position = x;
    in_first_sample = f;
    in_last_sample = l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expect_res(smooth_predict(x, f, l));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_tap(input logic [2:0] idx, input logic signed [15:0] w);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tap_w[idx] = w;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // Receiver: random ready, with occasional long pauses and one forced hold-off.
  always @(negedge clk) begin
    if (hold_rx) out_ready <= 1'b0;
    else if (rx_off > 0) begin
      rx_off--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      rx_off = $urandom_range(10, 60);
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 19) == 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
  end

  always @(posedge clk) begin
    smooth_res_t e;
    if (rst_n && out_valid && out_ready) begin
      n_res++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_smoothed_position, '0);
      end else begin
        e = pending_q.pop_front();
        if (out_smoothed_position !== e.pos)
          report_mismatch("smoothed_position", out_smoothed_position, e.pos);
        if (out_was_filtered !== e.filt)
          report_mismatch("was_filtered", 32'(out_was_filtered), 32'(e.filt));
        if (out_zero_gain_error !== e.zerr)
          report_mismatch("zero_gain_error", 32'(out_zero_gain_error), 32'(e.zerr));
        if (out_end_of_trajectory !== e.eot)
          report_mismatch("end_of_trajectory", 32'(out_end_of_trajectory), 32'(e.eot));
        n_filt += e.filt;
        n_zerr += e.zerr;
      end
    end
  end

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom();
    endcase
  endfunction

  task automatic rand_taps(input int mode);
    logic signed [15:0] w;
    for (int i = 0; i < ugfts_pkg::NCOEF; i++) begin
      case (mode)
        0: w = 16'($urandom());
        1: w = (i == 0) ? -16'sd32768 : 16'sd32767;
        2: w = 16'sd2048;
        default: w = ($urandom_range(0, 2) == 0) ? 16'sd0 : $signed(16'($urandom_range(0, 8192)));
      endcase
      write_tap(3'(i), w);
    end
  endtask

  stim_row_t dir_tab [20];
  smooth_res_t got_e;

  initial begin
    int n_items;
    logic signed [31:0] x, base;
    int len;
    for (int i = 0; i < ugfts_pkg::NCOEF; i++) tap_w[i] = 16'sd0;
    tap_w[ugfts_pkg::NCOEF - 1] = 16'sd16384;
    for (int i = 0; i < ugfts_pkg::TAPS; i++) hist[i] = '0;
    traj_start = '0;
    traj_phase = ugfts_pkg::CNT_IDLE;

    // pos, first, last, known, exp_pos, exp_filt, exp_zerr
    dir_tab[0]  = '{32'sd100, 1'b1, 1'b0, 1'b1, 32'sd100, 1'b0, 1'b0};
    dir_tab[1]  = '{32'sd200, 1'b0, 1'b0, 1'b1, 32'sd200, 1'b1, 1'b0};   // default taps: identity
    dir_tab[2]  = '{32'sd300, 1'b0, 1'b0, 1'b1, 32'sd300, 1'b1, 1'b0};
    dir_tab[3]  = '{32'sd400, 1'b0, 1'b1, 1'b1, 32'sd400, 1'b0, 1'b0};
    dir_tab[4]  = '{32'sh7fffffff, 1'b1, 1'b1, 1'b1, 32'sh7fffffff, 1'b0, 1'b0};
    dir_tab[5]  = '{32'sh80000000, 1'b0, 1'b1, 1'b1, 32'sh80000000, 1'b0, 1'b0};
    dir_tab[6]  = '{32'sd55, 1'b0, 1'b0, 1'b1, 32'sd55, 1'b0, 1'b0};     // no open trajectory
    dir_tab[7]  = '{32'sh80000000, 1'b0, 1'b0, 1'b1, 32'sh80000000, 1'b1, 1'b0};
    dir_tab[8]  = '{32'sh7fffffff, 1'b0, 1'b0, 1'b1, 32'sh7fffffff, 1'b1, 1'b0};
    dir_tab[9]  = '{32'sd0, 1'b0, 1'b1, 1'b1, 32'sd0, 1'b0, 1'b0};
    dir_tab[10] = '{32'sh7fffffff, 1'b1, 1'b0, 1'b1, 32'sh7fffffff, 1'b0, 1'b0};
    dir_tab[11] = '{32'sh80000000, 1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0}; // priming saturates
    dir_tab[12] = '{32'sd12345, 1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0};
    dir_tab[13] = '{-32'sd1, 1'b1, 1'b0, 1'b1, -32'sd1, 1'b0, 1'b0};     // first inside open trajectory
    dir_tab[14] = '{32'sd5, 1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0};
    dir_tab[15] = '{32'sd6, 1'b0, 1'b1, 1'b1, 32'sd6, 1'b0, 1'b0};
    dir_tab[16] = '{32'sd7, 1'b1, 1'b0, 1'b1, 32'sd7, 1'b0, 1'b0};
    dir_tab[17] = '{32'sd9, 1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0};
    dir_tab[18] = '{-32'sd40, 1'b0, 1'b0, 1'b0, 32'sd0, 1'b0, 1'b0};
    dir_tab[19] = '{32'sd1, 1'b0, 1'b1, 1'b1, 32'sd1, 1'b0, 1'b0};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (5) @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].known) begin
        got_e = smooth_predict(dir_tab[i].pos, dir_tab[i].first, dir_tab[i].last);
        // The typed row must agree with the predictor as well as with the block.
        if (got_e.pos !== dir_tab[i].exp_pos || got_e.filt !== dir_tab[i].exp_filt ||
            got_e.zerr !== dir_tab[i].exp_zerr)
          report_mismatch($sformatf("directed row %0d vs prediction", i), got_e.pos,
                          dir_tab[i].exp_pos);
        in_valid = 1'b1;
        in_sample_position = dir_tab[i].pos;
        in_first_sample = dir_tab[i].first;
        in_last_sample = dir_tab[i].last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expect_res(smooth_res_t'{dir_tab[i].exp_pos, dir_tab[i].exp_filt,
                                 dir_tab[i].exp_zerr, dir_tab[i].last});
        @(negedge clk);
        in_valid = 1'b0;
      end else begin
        send_sample(dir_tab[i].pos, dir_tab[i].first, dir_tab[i].last);
      end
      idle_gap();
    end
    drain();

    // Zero tap sum, then random phases with different weight sets.
    for (int i = 0; i < ugfts_pkg::NCOEF; i++)
      write_tap(3'(i), (i % 2) ? 16'sd100 : -16'sd100);
    send_sample(32'sd10, 1'b1, 1'b0);
    send_sample(32'sd20, 1'b0, 1'b0);
    send_sample(32'sd30, 1'b0, 1'b1);

    // Long receiver hold-off while the sender keeps offering items.
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(negedge clk);
        hold_rx = 1'b0;
      end
      begin
        send_sample(32'sd1, 1'b1, 1'b0);
        for (int i = 0; i < 6; i++) send_sample(rand_pos(), 1'b0, 1'b0);
      end
    join
    send_sample(32'sd0, 1'b0, 1'b1);
    drain();

    n_items = 0;
    for (int ph = 0; ph < 5; ph++) begin
      rand_taps(ph == 4 ? 0 : ph);
      while (n_items < (ph + 1) * 150) begin
        if ($urandom_range(0, 9) == 0) begin
          send_sample(rand_pos(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          n_items++;
        end else begin
          len = $urandom_range(2, 14);
          base = rand_pos();
          send_sample(base, 1'b1, 1'b0);
          for (int k = 0; k < len; k++) begin
            x = ($urandom_range(0, 4) == 0) ? rand_pos()
                : base + $signed($urandom_range(0, 4000)) - 2000;
            send_sample(x, 1'b0, 1'b0);
            idle_gap();
          end
          send_sample(rand_pos(), 1'b0, 1'b1);
          n_items += len + 2;
        end
        idle_gap();
      end
      drain();
    end

    $display("Covered %0d results: %0d filtered, %0d with zero tap sum,", n_res, n_filt, n_zerr);
    $display("over directed edge cases and five random coefficient sets.");
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still expected.", pending_q.size());
    $display("status: fail");
    $finish;
  end
endmodule
